FILE: hw/rtl/pdrc_pkg.sv
// Package for the pickup/delivery route checker.
// Holds the action codes, the cell operation type, the token control struct and sizes.
// No dependencies.
package pdrc_pkg;

    localparam int DEF_MAX_DELIVERIES = 64;
    localparam int DEF_NODE_BITS      = 24;

    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_VISIT = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LOAD  = 2'd2,
        OP_VISIT = 2'd3
    } pdrc_op_t;

    // Control part of an item as it travels down the cell chain.
    typedef struct packed {
        logic     valid;
        pdrc_op_t op;
        logic     last;
        logic     ovf;
    } pdrc_ctrl_t;

endpackage

FILE: hw/rtl/pdrc_cell.sv
// One cell of the route checker chain: holds one delivery entry and its marks,
// applies the passing item to it and hands the item to the next cell.
// Depends on pdrc_pkg.
module pdrc_cell #(
    parameter int NODE_BITS = pdrc_pkg::DEF_NODE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  pdrc_pkg::pdrc_ctrl_t         ctrl_in,
    input  logic [NODE_BITS-1:0]         key_a_in,
    input  logic [NODE_BITS-1:0]         key_b_in,
    input  logic [pdrc_pkg::COUNT_W-1:0] count_in,
    output pdrc_pkg::pdrc_ctrl_t         ctrl_out,
    output logic [NODE_BITS-1:0]         key_a_out,
    output logic [NODE_BITS-1:0]         key_b_out,
    output logic [pdrc_pkg::COUNT_W-1:0] count_out
);

    logic                         used_reg, used_next;
    logic                         picked_reg, picked_next;
    logic                         dropped_reg, dropped_next;
    logic [NODE_BITS-1:0]         pick_id_reg, drop_id_reg;
    logic                         id_wr;
    pdrc_pkg::pdrc_ctrl_t         ctrl_reg, ctrl_next;
    logic [NODE_BITS-1:0]         key_a_reg, key_b_reg;
    logic [pdrc_pkg::COUNT_W-1:0] count_reg, count_next;

    logic p_mark, d_mark;

    // Pickup first, then dropoff, so one visit can do both.
    assign p_mark = picked_reg | (pick_id_reg == key_a_in);
    assign d_mark = dropped_reg | (p_mark & (drop_id_reg == key_a_in));

    always_comb begin
        used_next    = used_reg;
        picked_next  = picked_reg;
        dropped_next = dropped_reg;
        id_wr        = 1'b0;
        ctrl_next    = ctrl_in;
        count_next   = count_in;
        if (ctrl_in.valid) begin
            case (ctrl_in.op)
                pdrc_pkg::OP_CLEAR: begin
                    used_next    = 1'b0;
                    picked_next  = 1'b0;
                    dropped_next = 1'b0;
                end
                pdrc_pkg::OP_LOAD: begin
                    // First free cell takes the entry; later cells see nothing.
                    if (!used_reg) begin
                        used_next      = 1'b1;
                        picked_next    = 1'b0;
                        dropped_next   = 1'b0;
                        id_wr          = 1'b1;
                        ctrl_next.op   = pdrc_pkg::OP_NONE;
                    end
                end
                pdrc_pkg::OP_VISIT: begin
                    if (used_reg) begin
                        if (ctrl_in.last) begin
                            if (!d_mark && count_in != pdrc_pkg::COUNT_MAX) begin
                                count_next = count_in + pdrc_pkg::COUNT_W'(1);
                            end
                            picked_next  = 1'b0;
                            dropped_next = 1'b0;
                        end else begin
                            picked_next  = p_mark;
                            dropped_next = d_mark;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= 1'b0;
            picked_reg  <= 1'b0;
            dropped_reg <= 1'b0;
            ctrl_reg    <= '0;
        end else if (advance) begin
            used_reg    <= used_next;
            picked_reg  <= picked_next;
            dropped_reg <= dropped_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_a_reg <= key_a_in;
            key_b_reg <= key_b_in;
            count_reg <= count_next;
            if (id_wr) begin
                pick_id_reg <= key_a_in;
                drop_id_reg <= key_b_in;
            end
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign key_a_out = key_a_reg;
    assign key_b_out = key_b_reg;
    assign count_out = count_reg;

endmodule

FILE: hw/rtl/pickup_delivery_route_check.sv
// Top level of the pickup/delivery route checker: input decode, load counter,
// chain of pdrc_cell instances and the result register. Depends on pdrc_pkg, pdrc_cell.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_action, s_pickup_node, s_dropoff_node,
//                                   s_visit_node, s_last_visit
//  m_       out  m_valid / m_ready  m_legal, m_undelivered_count, m_table_overflow
//
// One item is taken per cycle while the chain advances; each item walks the chain one cell
// per cycle, through every cell register and then the result register, before m_valid rises.
// Only a last visit produces a result; other items leave the chain silently.
// A held result with m_ready low freezes the whole chain and drops s_ready.
// Reset is synchronous and clears all marks, the entry count and the overflow flag.
module pickup_delivery_route_check #(
    parameter int MAX_DELIVERIES = pdrc_pkg::DEF_MAX_DELIVERIES,
    parameter int NODE_BITS      = pdrc_pkg::DEF_NODE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pdrc_pkg::ACTION_W-1:0] s_action,
    input  logic [NODE_BITS-1:0]          s_pickup_node,
    input  logic [NODE_BITS-1:0]          s_dropoff_node,
    input  logic [NODE_BITS-1:0]          s_visit_node,
    input  logic                          s_last_visit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_legal,
    output logic [pdrc_pkg::COUNT_W-1:0]  m_undelivered_count,
    output logic                          m_table_overflow
);

    localparam int CNT_W = $clog2(MAX_DELIVERIES + 1);

    logic advance;

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic             overflow_reg, overflow_next;

    pdrc_pkg::pdrc_ctrl_t         head_ctrl;
    logic [NODE_BITS-1:0]         head_key_a;
    logic [NODE_BITS-1:0]         head_key_b;

    pdrc_pkg::pdrc_ctrl_t         chain_ctrl  [0:MAX_DELIVERIES];
    logic [NODE_BITS-1:0]         chain_key_a [0:MAX_DELIVERIES];
    logic [NODE_BITS-1:0]         chain_key_b [0:MAX_DELIVERIES];
    logic [pdrc_pkg::COUNT_W-1:0] chain_count [0:MAX_DELIVERIES];

    logic                         m_valid_reg;
    logic                         legal_reg;
    logic [pdrc_pkg::COUNT_W-1:0] count_reg;
    logic                         ovf_reg;
    logic                         tail_result;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // Decode the incoming item into a chain token; track the table fill at entry.
    always_comb begin
        head_ctrl.valid  = s_valid;
        head_ctrl.op     = pdrc_pkg::OP_NONE;
        head_ctrl.last   = s_last_visit;
        head_ctrl.ovf    = overflow_reg;
        head_key_a       = s_visit_node;
        head_key_b       = s_dropoff_node;
        entry_count_next = entry_count_reg;
        overflow_next    = overflow_reg;
        unique case (s_action)
            pdrc_pkg::ACT_CLEAR: begin
                head_ctrl.op     = pdrc_pkg::OP_CLEAR;
                entry_count_next = '0;
                overflow_next    = 1'b0;
            end
            pdrc_pkg::ACT_LOAD: begin
                head_key_a = s_pickup_node;
                if (entry_count_reg < CNT_W'(MAX_DELIVERIES)) begin
                    head_ctrl.op     = pdrc_pkg::OP_LOAD;
                    entry_count_next = entry_count_reg + CNT_W'(1);
                end else begin
                    overflow_next = 1'b1;
                end
            end
            pdrc_pkg::ACT_VISIT: begin
                head_ctrl.op = pdrc_pkg::OP_VISIT;
            end
            default: begin
            end
        endcase
    end

    assign chain_ctrl[0]  = head_ctrl;
    assign chain_key_a[0] = head_key_a;
    assign chain_key_b[0] = head_key_b;
    assign chain_count[0] = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end else if (s_valid && s_ready) begin
            entry_count_reg <= entry_count_next;
            overflow_reg    <= overflow_next;
        end
    end

    for (genvar k = 0; k < MAX_DELIVERIES; k++) begin : g_cell
        pdrc_cell #(
            .NODE_BITS (NODE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .ctrl_in   (chain_ctrl[k]),
            .key_a_in  (chain_key_a[k]),
            .key_b_in  (chain_key_b[k]),
            .count_in  (chain_count[k]),
            .ctrl_out  (chain_ctrl[k+1]),
            .key_a_out (chain_key_a[k+1]),
            .key_b_out (chain_key_b[k+1]),
            .count_out (chain_count[k+1])
        );
    end

    assign tail_result = chain_ctrl[MAX_DELIVERIES].valid
                      && chain_ctrl[MAX_DELIVERIES].op == pdrc_pkg::OP_VISIT
                      && chain_ctrl[MAX_DELIVERIES].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= tail_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tail_result) begin
            count_reg <= chain_count[MAX_DELIVERIES];
            ovf_reg   <= chain_ctrl[MAX_DELIVERIES].ovf;
            legal_reg <= (chain_count[MAX_DELIVERIES] == '0)
                      && !chain_ctrl[MAX_DELIVERIES].ovf;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_legal             = legal_reg;
    assign m_undelivered_count = count_reg;
    assign m_table_overflow    = ovf_reg;

    // Key b is only needed for loads; the tail copies of both keys are unused.
    logic unused_tail;
    assign unused_tail = ^chain_key_a[MAX_DELIVERIES] ^ ^chain_key_b[MAX_DELIVERIES];

endmodule

FILE: test/pdrc_route_monitor.sv
// Scoreboard for the pickup/delivery route checker: mirrors the delivery table and
// the picked/dropped marks, predicts each path verdict and compares it on the m_ channel.
// Depends on pdrc_pkg.
module pdrc_route_monitor #(
    parameter int MAX_DELIVERIES = pdrc_pkg::DEF_MAX_DELIVERIES,
    parameter int NODE_BITS      = pdrc_pkg::DEF_NODE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [pdrc_pkg::ACTION_W-1:0] s_action,
    input  logic [NODE_BITS-1:0]          s_pickup_node,
    input  logic [NODE_BITS-1:0]          s_dropoff_node,
    input  logic [NODE_BITS-1:0]          s_visit_node,
    input  logic                          s_last_visit,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_legal,
    input  logic [pdrc_pkg::COUNT_W-1:0]  m_undelivered_count,
    input  logic                          m_table_overflow,
    output int                            mismatch_total,
    output int                            verdicts_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                         legal;
        logic [pdrc_pkg::COUNT_W-1:0] undelivered;
        logic                         overflow;
    } route_verdict_t;

    logic [NODE_BITS-1:0] pickup_table  [MAX_DELIVERIES];
    logic [NODE_BITS-1:0] dropoff_table [MAX_DELIVERIES];
    bit                   picked_flags  [MAX_DELIVERIES];
    bit                   dropped_flags [MAX_DELIVERIES];
    int                   entry_total;
    bit                   overflow_flag;
    route_verdict_t       expected_verdicts [$];

    initial begin
        mismatch_total       = 0;
        verdicts_outstanding = 0;
        entry_total          = 0;
        overflow_flag        = 1'b0;
    end

    task automatic clear_marks();
        int i;
        for (i = 0; i < MAX_DELIVERIES; i++) begin
            picked_flags[i]  = 1'b0;
            dropped_flags[i] = 1'b0;
        end
    endtask

    // Advance the mirrored table by one item; a last visit queues a verdict.
    task automatic track_route_item(input logic [pdrc_pkg::ACTION_W-1:0] act,
                                    input logic [NODE_BITS-1:0] pick,
                                    input logic [NODE_BITS-1:0] drop,
                                    input logic [NODE_BITS-1:0] node,
                                    input logic last);
        int             i;
        logic [31:0]    missing;
        route_verdict_t v;
        missing = '0;
        case (act)
            pdrc_pkg::ACT_CLEAR: begin
                clear_marks();
                entry_total   = 0;
                overflow_flag = 1'b0;
            end
            pdrc_pkg::ACT_LOAD: begin
                if (entry_total < MAX_DELIVERIES) begin
                    pickup_table[entry_total]  = pick;
                    dropoff_table[entry_total] = drop;
                    picked_flags[entry_total]  = 1'b0;
                    dropped_flags[entry_total] = 1'b0;
                    entry_total++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            pdrc_pkg::ACT_VISIT: begin
                // pickups before dropoffs so one visit can do both
                for (i = 0; i < entry_total; i++)
                    if (pickup_table[i] == node) picked_flags[i] = 1'b1;
                for (i = 0; i < entry_total; i++)
                    if (dropoff_table[i] == node && picked_flags[i]) dropped_flags[i] = 1'b1;
                if (last) begin
                    for (i = 0; i < entry_total; i++)
                        if (!dropped_flags[i]) missing++;
                    v.legal       = (missing == 0) && !overflow_flag;
                    v.undelivered = (missing > 32'(pdrc_pkg::COUNT_MAX))
                                  ? pdrc_pkg::COUNT_MAX
                                  : missing[pdrc_pkg::COUNT_W-1:0];
                    v.overflow    = overflow_flag;
                    expected_verdicts.push_back(v);
                    clear_marks();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        route_verdict_t want;
        if (!aresetn) begin
            clear_marks();
            entry_total   = 0;
            overflow_flag = 1'b0;
            expected_verdicts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: unexpected verdict legal=%0b undelivered=%0d overflow=%0b",
                                 $realtime, m_legal, m_undelivered_count, m_table_overflow);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_legal !== want.legal || m_undelivered_count !== want.undelivered ||
                        m_table_overflow !== want.overflow) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $write("%0t: verdict mismatch: expected legal=%0b undelivered=%0d",
                                   $realtime, want.legal, want.undelivered);
                            $display(" overflow=%0b, got legal=%0b undelivered=%0d overflow=%0b",
                                     want.overflow, m_legal, m_undelivered_count,
                                     m_table_overflow);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                track_route_item(s_action, s_pickup_node, s_dropoff_node, s_visit_node,
                                 s_last_visit);
        end
        verdicts_outstanding = expected_verdicts.size();
    end

endmodule

FILE: test/tb_pickup_delivery_route_check.sv
// Testbench top for the pickup/delivery route checker: clock, reset, route stimulus,
// receiver stalls, watchdog and the final verdict.
// Depends on pdrc_pkg, pickup_delivery_route_check and pdrc_route_monitor.
module tb_pickup_delivery_route_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEL     = pdrc_pkg::DEF_MAX_DELIVERIES;
    localparam int NODE_BITS   = pdrc_pkg::DEF_NODE_BITS;
    localparam int ITEM_TARGET = 1450;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_TAIL  = MAX_DEL + 20;

    localparam logic [pdrc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic [NODE_BITS-1:0] node_id_t;

    typedef enum int {
        ROUTE_SPLIT,
        ROUTE_PAIRED,
        ROUTE_REVERSED,
        ROUTE_GAPPED,
        ROUTE_WILD
    } route_shape_e;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [pdrc_pkg::ACTION_W-1:0] s_action       = pdrc_pkg::ACT_CLEAR;
    node_id_t                      s_pickup_node  = '0;
    node_id_t                      s_dropoff_node = '0;
    node_id_t                      s_visit_node   = '0;
    logic                          s_last_visit   = 1'b0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic                          m_legal;
    logic [pdrc_pkg::COUNT_W-1:0]  m_undelivered_count;
    logic                          m_table_overflow;

    int mismatch_total;
    int verdicts_outstanding;
    int items_sent         = 0;
    int sender_idle_pct    = 18;
    int receiver_stall_pct = 67;
    int hold_requests      = 0;
    int holds_served       = 0;
    int quiet_cycles       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pickup_delivery_route_check #(
        .MAX_DELIVERIES (MAX_DEL),
        .NODE_BITS      (NODE_BITS)
    ) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_pickup_node       (s_pickup_node),
        .s_dropoff_node      (s_dropoff_node),
        .s_visit_node        (s_visit_node),
        .s_last_visit        (s_last_visit),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_legal             (m_legal),
        .m_undelivered_count (m_undelivered_count),
        .m_table_overflow    (m_table_overflow)
    );

    pdrc_route_monitor #(
        .MAX_DELIVERIES (MAX_DEL),
        .NODE_BITS      (NODE_BITS)
    ) i_route_monitor (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_pickup_node        (s_pickup_node),
        .s_dropoff_node       (s_dropoff_node),
        .s_visit_node         (s_visit_node),
        .s_last_visit         (s_last_visit),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_legal              (m_legal),
        .m_undelivered_count  (m_undelivered_count),
        .m_table_overflow     (m_table_overflow),
        .mismatch_total       (mismatch_total),
        .verdicts_outstanding (verdicts_outstanding)
    );

    // Receiver: random stalls, or one long hold-off per request from the sender.
    always begin : receiver
        @(negedge aclk);
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            m_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge aclk);
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic node_id_t random_node();
        logic [31:0] r;
        r = $urandom();
        return r[NODE_BITS-1:0];
    endfunction

    function automatic logic random_bit();
        logic [31:0] r;
        r = $urandom();
        return r[0];
    endfunction

    // Offer one item at a falling edge, with random idle cycles ahead of it.
    task automatic offer_item(input logic [pdrc_pkg::ACTION_W-1:0] act, input node_id_t pick,
                              input node_id_t drop, input node_id_t node, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_pickup_node  <= pick;
        s_dropoff_node <= drop;
        s_visit_node   <= node;
        s_last_visit   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act != ACT_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic offer_visit(input node_id_t node, input logic last);
        offer_item(pdrc_pkg::ACT_VISIT, random_node(), random_node(), node, last);
    endtask

    task automatic offer_load(input node_id_t pick, input node_id_t drop);
        offer_item(pdrc_pkg::ACT_LOAD, pick, drop, random_node(), random_bit());
    endtask

    // Hold the input quiet until every predicted verdict has come back.
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (verdicts_outstanding != 0) @(negedge aclk);
    endtask

    task automatic shuffle_tail(ref node_id_t q[$], input int from);
        node_id_t t;
        int       j;
        int       k;
        for (j = q.size() - 1; j > from; j--) begin
            k    = $urandom_range(from, j);
            t    = q[j];
            q[j] = q[k];
            q[k] = t;
        end
    endtask

    // Clear, load a table over a small node pool, then run paths over it.
    task automatic run_route_scenario(input int n_loads, input int n_paths,
                                      input bit short_paths);
        node_id_t     pool  [$];
        node_id_t     picks [$];
        node_id_t     drops [$];
        node_id_t     route [$];
        route_shape_e shape;
        int           pool_n;
        int           n_kept;
        int           r;
        int           j;
        int           k;
        pool_n = $urandom_range(1, 8);
        for (j = 0; j < pool_n; j++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      pool.push_back('0);
            else if (r == 1) pool.push_back('1);
            else             pool.push_back(random_node());
        end
        offer_item(pdrc_pkg::ACT_CLEAR, random_node(), random_node(), random_node(),
                   random_bit());
        for (j = 0; j < n_loads; j++) begin
            picks.push_back(pool[$urandom_range(0, pool_n - 1)]);
            drops.push_back(pool[$urandom_range(0, pool_n - 1)]);
            if ($urandom_range(0, 24) == 0)
                offer_item(ACT_UNUSED, random_node(), random_node(), random_node(), random_bit());
            offer_load(picks[j], drops[j]);
        end
        n_kept = (n_loads > MAX_DEL) ? MAX_DEL : n_loads;
        for (k = 0; k < n_paths; k++) begin
            route.delete();
            r = $urandom_range(0, 9);
            if (short_paths || r >= 8) shape = ROUTE_WILD;
            else if (r <= 2)           shape = ROUTE_SPLIT;
            else if (r <= 5)           shape = ROUTE_PAIRED;
            else if (r == 6)           shape = ROUTE_REVERSED;
            else                       shape = ROUTE_GAPPED;
            case (shape)
                ROUTE_SPLIT: begin
                    for (j = 0; j < n_kept; j++) route.push_back(picks[j]);
                    shuffle_tail(route, 0);
                    for (j = 0; j < n_kept; j++) route.push_back(drops[j]);
                    shuffle_tail(route, n_kept);
                end
                ROUTE_REVERSED: begin
                    for (j = 0; j < n_kept; j++) route.push_back(drops[j]);
                    for (j = 0; j < n_kept; j++) route.push_back(picks[j]);
                end
                ROUTE_PAIRED, ROUTE_GAPPED: begin
                    for (j = 0; j < n_kept; j++) begin
                        route.push_back(picks[j]);
                        route.push_back(drops[j]);
                    end
                    if (shape == ROUTE_GAPPED && route.size() > 0)
                        route.delete($urandom_range(0, route.size() - 1));
                end
                default: begin
                    for (j = $urandom_range(1, short_paths ? 2 : 8); j > 0; j--)
                        route.push_back(($urandom_range(0, 3) != 0)
                                        ? pool[$urandom_range(0, pool_n - 1)] : random_node());
                end
            endcase
            if (route.size() == 0 || $urandom_range(0, 4) == 0)
                route.push_back(random_node());
            for (j = 0; j < route.size(); j++) begin
                if ($urandom_range(0, 24) == 0)
                    offer_item(ACT_UNUSED, random_node(), random_node(), random_node(),
                               random_bit());
                offer_visit(route[j], j == route.size() - 1);
            end
        end
    endtask

    initial begin : stimulus
        int  r;
        int  n_loads;
        bit  flood_done;
        flood_done = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table gives a legal verdict with nothing undelivered
        offer_visit(random_node(), 1'b1);
        offer_item(ACT_UNUSED, '1, '1, '1, 1'b1);
        offer_load('1, '0);
        offer_load('0, '0);
        offer_load(24'h123456, '1);
        // dropoff seen before pickup leaves deliveries open
        offer_visit('0, 1'b0);
        offer_visit('1, 1'b0);
        offer_visit(24'h123456, 1'b1);
        // pickup and dropoff on the same visit
        offer_visit('0, 1'b1);
        offer_visit('1, 1'b0);
        offer_visit(24'h123456, 1'b0);
        offer_item(ACT_UNUSED, '0, '0, '0, 1'b0);
        offer_visit('0, 1'b0);
        offer_visit('1, 1'b1);
        offer_item(pdrc_pkg::ACT_CLEAR, '1, '1, '1, 1'b1);
        offer_visit('0, 1'b1);
        offer_load(24'h00abcd, 24'h00abcd);
        offer_visit(24'h00abcd, 1'b1);
        offer_load(24'h800000, 24'h7fffff);
        offer_visit(24'h7fffff, 1'b0);
        offer_visit(24'h800000, 1'b1);
        drain_verdicts();

        // full table, then loads past capacity
        run_route_scenario(MAX_DEL, 1, 1'b0);
        run_route_scenario(MAX_DEL + 3, 2, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 2 * ITEM_TARGET / 3) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
                if (!flood_done) begin
                    // long receiver hold while many short paths keep coming
                    flood_done = 1'b1;
                    hold_requests++;
                    run_route_scenario(2, 40, 1'b1);
                end
            end else if (items_sent >= ITEM_TARGET / 3) begin
                sender_idle_pct    = 67;
                receiver_stall_pct = 18;
            end
            r = $urandom_range(0, 99);
            if (r < 80)      n_loads = $urandom_range(0, 8);
            else if (r < 96) n_loads = $urandom_range(9, 30);
            else             n_loads = $urandom_range(MAX_DEL - 4, MAX_DEL + 6);
            run_route_scenario(n_loads, $urandom_range(1, 3), 1'b0);
        end

        drain_verdicts();
        repeat (DRAIN_TAIL) @(negedge aclk);
        if (mismatch_total == 0 && verdicts_outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
